FILE: src/speech_command_frame_builder_assert.svh
// Assertion macros shared by the speech command frame builder RTL.
// No dependencies; taken in by the modules that carry assertions.
`ifndef SPEECH_COMMAND_FRAME_BUILDER_ASSERT_SVH
`define SPEECH_COMMAND_FRAME_BUILDER_ASSERT_SVH

// Same-cycle implication, switched off while reset is held.
`define SCFB_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is held.
`define SCFB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/scfb_pkg.sv
// Shared types, constants and codes of the speech command frame builder.
// No dependencies; imported by the front, sequencer, transmit stage, top level and bench.
package scfb_pkg;

    // Sizes of the frame builder.
    localparam int MAX_TEXT   = 190;
    localparam int CMD_BYTES  = 17;
    localparam int HOLD_DEPTH = 32;
    localparam int HOLD_CW    = $clog2(HOLD_DEPTH + 1);
    localparam int RUN_MAX    = 15;
    localparam int RUN_W      = $clog2(RUN_MAX + 1);
    localparam int FIFO_DEPTH = 32;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);
    localparam int NBYTES_W   = $clog2(CMD_BYTES + 1);

    // Frame bytes.
    localparam logic [7:0] BYTE_HEAD   = 8'hFD;
    localparam logic [7:0] BYTE_ZERO   = 8'h00;
    localparam logic [7:0] FIXED_LEN   = 8'h02;
    localparam logic [7:0] CMD_SPEAK   = 8'h01;
    localparam logic [7:0] CMD_STOP    = 8'h02;
    localparam logic [7:0] CHK_STOP    = 8'hFD;
    localparam logic [7:0] CMD_SLEEP   = 8'h88;
    localparam logic [7:0] CHK_SLEEP   = 8'h77;
    localparam logic [7:0] CMD_WAKE    = 8'h21;
    localparam logic [7:0] CHK_WAKE    = 8'hDE;
    localparam logic [7:0] ASCII_LBRK  = 8'h5B;
    localparam logic [7:0] ASCII_RBRK  = 8'h5D;
    localparam logic [7:0] ASCII_M     = 8'h6D;
    localparam logic [7:0] ASCII_V     = 8'h76;
    localparam logic [7:0] ASCII_ZERO  = 8'h30;

    // Item function codes.
    typedef enum logic [2:0] {
        FUNC_START = 3'd0,
        FUNC_TEXT  = 3'd1,
        FUNC_STOP  = 3'd2,
        FUNC_SLEEP = 3'd3,
        FUNC_WAKE  = 3'd4
    } t_func;

    // Classified command kinds handed from the front to the sequencer.
    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_START = 2'd1,
        KIND_TEXT  = 2'd2,
        KIND_FIXED = 2'd3
    } t_kind;

    // One classified command: its prepared bytes and frame-end marks.
    typedef struct packed {
        t_kind                          kind;
        logic [NBYTES_W-1:0]            nbytes;
        logic [CMD_BYTES-1:0]           ends;
        logic [CMD_BYTES-1:0][7:0]      bytes;
        logic [7:0]                     tlen;
    } t_cmd;

    // Byte push from the sequencer into the transmit queue.
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       fend;
    } t_byte_push;

    // Run length push: how many queued words the current item releases.
    typedef struct packed {
        logic             valid;
        logic [RUN_W-1:0] len;
    } t_run_push;

    // Fill status of the transmit queues back to the sequencer.
    typedef struct packed {
        logic byte_full;
        logic run_full;
    } t_tx_status;

endpackage

FILE: src/scfb_if.sv
// Valid/ready channel interfaces for input items and result words.
// Depends on nothing; used by the front, the transmit stage and the top level.
interface scfb_item_if;
    logic       valid;
    logic       ready;
    logic [2:0] func;
    logic [7:0] music_volume;
    logic [3:0] music_number;
    logic [7:0] voice_volume;
    logic [2:0] text_encoding;
    logic [7:0] text_length;
    logic [7:0] text_byte;

    modport source (
        output valid, func, music_volume, music_number, voice_volume,
        output text_encoding, text_length, text_byte,
        input  ready
    );
    modport sink (
        input  valid, func, music_volume, music_number, voice_volume,
        input  text_encoding, text_length, text_byte,
        output ready
    );
endinterface

interface scfb_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       last_of_run;
    logic       frame_end;

    modport source (output valid, frame_byte, last_of_run, frame_end, input ready);
    modport sink   (input  valid, frame_byte, last_of_run, frame_end, output ready);
endinterface

FILE: src/scfb_front.sv
// Front end: accepts items, classifies them and prepares their frame bytes.
// Depends on scfb_pkg and scfb_item_if; holds a two-entry command queue toward the sequencer.
module scfb_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    scfb_item_if.sink         i_item,
    output scfb_pkg::t_cmd    o_cmd,
    output logic              o_cmd_valid,
    input  logic              i_cmd_pop
);
    import scfb_pkg::*;

    // Decimal form of an 8-bit value, most significant digit first.
    typedef struct packed {
        logic [1:0]      ndig;
        logic [2:0][7:0] ch;
    } t_dec;

    function automatic t_dec to_dec(input logic [7:0] v);
        t_dec        d;
        logic [1:0]  h;
        logic [6:0]  r;
        logic [14:0] p;
        logic [3:0]  t;
        logic [3:0]  u;
        h = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
        r = 7'(v - 8'(h) * 8'd100);
        // Tens digit by reciprocal multiply, exact for values below 100.
        p = 15'(r) * 15'd205;
        t = p[14:11];
        u = 4'(r - 7'(t) * 7'd10);
        d = '0;
        if (h != 2'd0) begin
            d.ndig  = 2'd3;
            d.ch[0] = ASCII_ZERO + 8'(h);
            d.ch[1] = ASCII_ZERO + 8'(t);
            d.ch[2] = ASCII_ZERO + 8'(u);
        end else if (t != 4'd0) begin
            d.ndig  = 2'd2;
            d.ch[0] = ASCII_ZERO + 8'(t);
            d.ch[1] = ASCII_ZERO + 8'(u);
        end else begin
            d.ndig  = 2'd1;
            d.ch[0] = ASCII_ZERO + 8'(u);
        end
        return d;
    endfunction

    // Control string "[xN]" packed from entry 0 upward.
    function automatic logic [5:0][7:0] ctrl_str(input logic [7:0] letter, input t_dec d);
        logic [5:0][7:0] s;
        s    = '0;
        s[0] = ASCII_LBRK;
        s[1] = letter;
        for (int k = 0; k < 3; k++) begin
            if (k < int'(d.ndig)) begin
                s[2 + k] = d.ch[k];
            end
        end
        s[3'd2 + 3'(d.ndig)] = ASCII_RBRK;
        return s;
    endfunction

    // Fixed five-byte frame, sent once or twice.
    function automatic t_cmd fixed_cmd(input logic [7:0] code, input logic [7:0] chk,
                                       input logic twice);
        t_cmd c;
        c = '0;
        c.kind = KIND_FIXED;
        for (int f = 0; f < 2; f++) begin
            c.bytes[5 * f + 0] = BYTE_HEAD;
            c.bytes[5 * f + 1] = BYTE_ZERO;
            c.bytes[5 * f + 2] = FIXED_LEN;
            c.bytes[5 * f + 3] = code;
            c.bytes[5 * f + 4] = chk;
        end
        c.ends[4] = 1'b1;
        c.ends[9] = twice;
        c.nbytes  = twice ? NBYTES_W'(10) : NBYTES_W'(5);
        return c;
    endfunction

    t_dec            w_mdec;
    t_dec            w_vdec;
    logic [5:0][7:0] w_mstr;
    logic [5:0][7:0] w_vstr;
    logic [2:0]      w_mlen;
    logic [2:0]      w_vlen;
    logic [7:0]      w_tsat;
    logic [8:0]      w_dlen;
    t_cmd            w_cmd;

    t_cmd            r_q [2];
    logic            r_wr;
    logic            r_rd;
    logic [1:0]      r_cnt;
    logic            w_push;
    logic            w_pop;

    // Classify the item and lay out the bytes it will emit.
    always_comb begin
        w_mdec = to_dec(i_item.music_volume);
        w_vdec = to_dec(i_item.voice_volume);
        w_mstr = ctrl_str(ASCII_M, w_mdec);
        w_vstr = ctrl_str(ASCII_V, w_vdec);
        w_mlen = 3'(w_mdec.ndig) + 3'd3;
        w_vlen = 3'(w_vdec.ndig) + 3'd3;
        w_tsat = (i_item.text_length > 8'(MAX_TEXT)) ? 8'(MAX_TEXT) : i_item.text_length;
        w_dlen = 9'(w_mlen) + 9'(w_vlen) + 9'(w_tsat) + 9'd3;
        w_cmd  = '0;
        case (i_item.func)
            FUNC_START: begin
                w_cmd.kind     = KIND_START;
                w_cmd.nbytes   = NBYTES_W'(5) + NBYTES_W'(w_mlen) + NBYTES_W'(w_vlen);
                w_cmd.tlen     = w_tsat;
                w_cmd.bytes[0] = BYTE_HEAD;
                w_cmd.bytes[1] = 8'(w_dlen[8]);
                w_cmd.bytes[2] = w_dlen[7:0];
                w_cmd.bytes[3] = CMD_SPEAK;
                w_cmd.bytes[4] = {1'b0, i_item.music_number, i_item.text_encoding};
                // The two control strings follow each other without gaps.
                for (int p = 0; p < CMD_BYTES - 5; p++) begin
                    if (p < int'(w_mlen)) begin
                        w_cmd.bytes[5 + p] = w_mstr[3'(p)];
                    end else if (p - int'(w_mlen) < 6) begin
                        w_cmd.bytes[5 + p] = w_vstr[3'(p - int'(w_mlen))];
                    end
                end
            end
            FUNC_TEXT: begin
                w_cmd.kind     = KIND_TEXT;
                w_cmd.nbytes   = NBYTES_W'(1);
                w_cmd.bytes[0] = i_item.text_byte;
            end
            FUNC_STOP:  w_cmd = fixed_cmd(CMD_STOP, CHK_STOP, 1'b0);
            FUNC_SLEEP: w_cmd = fixed_cmd(CMD_SLEEP, CHK_SLEEP, 1'b0);
            FUNC_WAKE:  w_cmd = fixed_cmd(CMD_WAKE, CHK_WAKE, 1'b1);
            default:    w_cmd.kind = KIND_NONE;
        endcase
    end

    // Two-entry command queue toward the sequencer.
    assign i_item.ready = (r_cnt != 2'd2);
    assign w_push       = i_item.valid && i_item.ready;
    assign w_pop        = i_cmd_pop && (r_cnt != 2'd0);
    assign o_cmd        = r_q[r_rd];
    assign o_cmd_valid  = (r_cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr <= ~r_wr;
            end
            if (w_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

endmodule

FILE: src/scfb_gen.sv
// Back-end sequencer: walks each command one byte per cycle while no transmit queue is full,
// keeps the check byte and the hold count, and releases runs. Depends on scfb_pkg.
module scfb_gen (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  scfb_pkg::t_cmd         i_cmd,
    input  logic                   i_cmd_valid,
    output logic                   o_cmd_pop,
    output scfb_pkg::t_byte_push   o_byte,
    output scfb_pkg::t_run_push    o_run,
    input  scfb_pkg::t_tx_status   i_tx
);
    import scfb_pkg::*;

    logic [NBYTES_W-1:0] r_idx;
    logic [7:0]          r_chk;
    logic [7:0]          r_rem;
    logic                r_open;
    logic [HOLD_CW-1:0]  r_hold;

    logic [7:0]          n_chk;
    logic [7:0]          n_rem;
    logic                n_open;

    logic                w_emit;
    logic [7:0]          w_byte;
    logic                w_end;
    logic                w_last;
    logic [7:0]          w_base;
    logic                w_keep;
    logic [HOLD_CW-1:0]  w_sum;
    logic [RUN_W-1:0]    w_run;
    logic                w_run_go;
    logic                w_adv;

    // Byte selection and frame state update for the current step.
    always_comb begin
        w_emit = 1'b0;
        w_byte = '0;
        w_end  = 1'b0;
        w_last = 1'b1;
        w_base = (r_idx == '0) ? '0 : r_chk;
        n_chk  = r_chk;
        n_rem  = r_rem;
        n_open = r_open;
        case (i_cmd.kind)
            KIND_START: begin
                w_emit = 1'b1;
                if (r_idx < i_cmd.nbytes) begin
                    w_byte = i_cmd.bytes[r_idx];
                    n_chk  = w_base ^ w_byte;
                    w_last = (r_idx == i_cmd.nbytes - NBYTES_W'(1)) && (i_cmd.tlen != '0);
                    if (w_last) begin
                        n_open = 1'b1;
                        n_rem  = i_cmd.tlen;
                    end
                end else begin
                    // Empty text: the check byte closes the frame at once.
                    w_byte = r_chk;
                    w_end  = 1'b1;
                    n_chk  = '0;
                    n_rem  = '0;
                    n_open = 1'b0;
                end
            end
            KIND_TEXT: begin
                if (r_open && (r_idx == '0)) begin
                    w_emit = 1'b1;
                    w_byte = i_cmd.bytes[0];
                    n_chk  = r_chk ^ w_byte;
                    n_rem  = r_rem - 8'd1;
                    w_last = (r_rem != 8'd1);
                end else if (r_open) begin
                    w_emit = 1'b1;
                    w_byte = r_chk;
                    w_end  = 1'b1;
                    n_chk  = '0;
                    n_rem  = '0;
                    n_open = 1'b0;
                end
            end
            KIND_FIXED: begin
                w_emit = 1'b1;
                w_byte = i_cmd.bytes[r_idx];
                w_end  = i_cmd.ends[r_idx];
                w_last = (r_idx == i_cmd.nbytes - NBYTES_W'(1));
                n_chk  = '0;
                n_rem  = '0;
                n_open = 1'b0;
            end
            default: begin
                w_emit = 1'b0;
            end
        endcase
    end

    // Hold count: bytes beyond the hold depth are dropped, the last step of each item
    // releases up to RUN_MAX words.
    always_comb begin
        w_keep   = w_emit && (r_hold < HOLD_CW'(HOLD_DEPTH));
        w_sum    = r_hold + HOLD_CW'(w_keep);
        w_run    = (w_sum > HOLD_CW'(RUN_MAX)) ? RUN_W'(RUN_MAX) : w_sum[RUN_W-1:0];
        w_run_go = w_last && (w_run != '0);
        w_adv    = i_cmd_valid && !(w_keep && i_tx.byte_full) && !(w_run_go && i_tx.run_full);

        o_byte.valid = w_adv && w_keep;
        o_byte.data  = w_byte;
        o_byte.fend  = w_end;
        o_run.valid  = w_adv && w_run_go;
        o_run.len    = w_run;
        o_cmd_pop    = w_adv && w_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= '0;
            r_chk  <= '0;
            r_rem  <= '0;
            r_open <= 1'b0;
            r_hold <= '0;
        end else if (w_adv) begin
            r_idx  <= w_last ? '0 : r_idx + NBYTES_W'(1);
            r_chk  <= n_chk;
            r_rem  <= n_rem;
            r_open <= n_open;
            r_hold <= w_last ? w_sum - HOLD_CW'(w_run) : w_sum;
        end
    end

endmodule

FILE: src/scfb_tx.sv
// Transmit stage: word queue, run-length queue and the output register.
// Depends on scfb_pkg, scfb_result_if and the assertion macro header.
`include "speech_command_frame_builder_assert.svh"

module scfb_tx (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  scfb_pkg::t_byte_push   i_byte,
    input  scfb_pkg::t_run_push    i_run,
    output scfb_pkg::t_tx_status   o_status,
    scfb_result_if.source          o_result
);
    import scfb_pkg::*;

    typedef struct packed {
        logic       fend;
        logic [7:0] data;
    } t_qword;

    function automatic logic [FIFO_AW-1:0] ptr_inc(input logic [FIFO_AW-1:0] p);
        return (p == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : p + FIFO_AW'(1);
    endfunction

    t_qword             r_bmem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_bwr;
    logic [FIFO_AW-1:0] r_brd;
    logic [FIFO_CW-1:0] r_bcnt;

    logic [RUN_W-1:0]   r_rmem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_rwr;
    logic [FIFO_AW-1:0] r_rrd;
    logic [FIFO_CW-1:0] r_rcnt;

    logic [RUN_W-1:0]   r_left;
    logic               r_ovalid;
    logic [7:0]         r_obyte;
    logic               r_olast;
    logic               r_oend;

    logic               w_run_act;
    logic               w_run_avail;
    logic               w_load;
    logic               w_rpop;

    // Queue status toward the sequencer.
    assign o_status.byte_full = (r_bcnt == FIFO_CW'(FIFO_DEPTH));
    assign o_status.run_full  = (r_rcnt == FIFO_CW'(FIFO_DEPTH));

    // A word leaves only inside a released run; the run's first word pops its length.
    assign w_run_act   = (r_left != '0);
    assign w_run_avail = w_run_act || (r_rcnt != '0);
    assign w_load      = (r_bcnt != '0) && w_run_avail && (!r_ovalid || o_result.ready);
    assign w_rpop      = w_load && !w_run_act;

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (i_byte.valid) begin
            r_bmem[r_bwr] <= '{fend: i_byte.fend, data: i_byte.data};
        end
        if (i_run.valid) begin
            r_rmem[r_rwr] <= i_run.len;
        end
    end

    // Queue pointers, run counter and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bwr    <= '0;
            r_brd    <= '0;
            r_bcnt   <= '0;
            r_rwr    <= '0;
            r_rrd    <= '0;
            r_rcnt   <= '0;
            r_left   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_byte.valid) begin
                r_bwr <= ptr_inc(r_bwr);
            end
            if (w_load) begin
                r_brd  <= ptr_inc(r_brd);
                r_left <= (w_run_act ? r_left : r_rmem[r_rrd]) - RUN_W'(1);
            end
            r_bcnt <= r_bcnt + FIFO_CW'(i_byte.valid) - FIFO_CW'(w_load);
            if (i_run.valid) begin
                r_rwr <= ptr_inc(r_rwr);
            end
            if (w_rpop) begin
                r_rrd <= ptr_inc(r_rrd);
            end
            r_rcnt <= r_rcnt + FIFO_CW'(i_run.valid) - FIFO_CW'(w_rpop);
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (o_result.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_obyte <= r_bmem[r_brd].data;
            r_oend  <= r_bmem[r_brd].fend;
            r_olast <= ((w_run_act ? r_left : r_rmem[r_rrd]) == RUN_W'(1));
        end
    end

    assign o_result.valid       = r_ovalid;
    assign o_result.frame_byte  = r_obyte;
    assign o_result.last_of_run = r_olast;
    assign o_result.frame_end   = r_oend;

    // The sequencer never pushes into a full word queue.
    `SCFB_ASSERT_IMPL(a_word_room, i_clk, i_rst_n, i_byte.valid, !o_status.byte_full, "queue full")
    // A released run always has its words already queued.
    `SCFB_ASSERT_IMPL(a_run_has_words, i_clk, i_rst_n, w_run_avail, r_bcnt != '0, "empty run")
    // Run lengths pushed by the sequencer are never zero.
    `SCFB_ASSERT_IMPL(a_run_nonzero, i_clk, i_rst_n, i_run.valid, i_run.len != '0, "zero run")
    // Inside a run each sent word counts the remainder down.
    `SCFB_ASSERT_NEXT(a_run_down, i_clk, i_rst_n, w_load && w_run_act, r_left < $past(r_left), "run skip")

endmodule

FILE: src/speech_command_frame_builder.sv
// Items pass the two-entry command queue, the sequencer, the word and run-length queues and the
// output register. The sequencer walks one frame byte per cycle while a command waits and
// neither transmit queue is full; the output port carries one word per cycle while a run is
// released, words are queued and the receiver takes them.
// Reset: synchronous, active low; clears the queues, the check byte and the frame state.
// Top level of the speech command frame builder; depends on scfb_pkg, scfb_if and submodules.
module speech_command_frame_builder (
    input  logic          i_clk,
    input  logic          i_rst_n,
    scfb_item_if.sink     i_item,
    scfb_result_if.source o_result
);
    import scfb_pkg::*;

    t_cmd       w_cmd;
    logic       w_cmd_valid;
    logic       w_cmd_pop;
    t_byte_push w_byte;
    t_run_push  w_run;
    t_tx_status w_status;

    scfb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .o_cmd       (w_cmd),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_pop   (w_cmd_pop)
    );

    scfb_gen u_gen (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_pop   (w_cmd_pop),
        .o_byte      (w_byte),
        .o_run       (w_run),
        .i_tx        (w_status)
    );

    scfb_tx u_tx (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_byte   (w_byte),
        .i_run    (w_run),
        .o_status (w_status),
        .o_result (o_result)
    );

endmodule

FILE: bench/speech_command_frame_builder_tb.sv
// Self-checking testbench for the speech command frame builder: random and directed items
// are predicted in-bench and every result word is compared. Depends on scfb_pkg, scfb_if
// and the speech_command_frame_builder RTL.
module speech_command_frame_builder_tb;
    import scfb_pkg::*;

    // One input item as the bench keeps it.
    typedef struct {
        logic [2:0] func;
        logic [7:0] music_volume;
        logic [3:0] music_number;
        logic [7:0] voice_volume;
        logic [2:0] text_encoding;
        logic [7:0] text_length;
        logic [7:0] text_byte;
    } t_speech_item;

    // One result word.
    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_of_run;
        logic       frame_end;
    } t_frame_word;

    localparam int RANDOM_ITEMS = 290;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES = 40;

    logic i_clk = 1'b0;
    logic i_rst_n;

    scfb_item_if   item_ch ();
    scfb_result_if result_ch ();

    speech_command_frame_builder u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (result_ch)
    );

    // Stimulus and scoreboard storage.
    t_speech_item item_pending[$];
    t_speech_item item_offered;
    t_frame_word  held_words[$];
    t_frame_word  expected_words[$];
    int           item_total;
    int           items_accepted;
    int           mismatch_count;
    int           rx_hold_left;
    logic         rx_hold_done;

    // Frame state of the predictor.
    logic [7:0] frame_check;
    logic [7:0] text_left;
    logic       frame_open;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Idle percentage for each side: sender light and receiver heavy, then swapped, then none.
    function automatic int idle_pct(bit receiver);
        int phase;
        phase = (items_accepted < item_total / 3) ? 0 :
                (items_accepted < 2 * item_total / 3) ? 1 : 2;
        case (phase)
            0: return receiver ? 57 : 15;
            1: return receiver ? 15 : 57;
            default: return 0;
        endcase
    endfunction

    // ---------------------------------------------------------------- predictor

    // Append a byte to the hold queue; bytes that do not fit are lost.
    function automatic void hold_word(logic [7:0] b, logic fend);
        t_frame_word w;
        w.frame_byte  = b;
        w.last_of_run = 1'b0;
        w.frame_end   = fend;
        if (held_words.size() < HOLD_DEPTH)
            held_words.push_back(w);
    endfunction

    // Append a byte that counts toward the check byte.
    function automatic void hold_checked(logic [7:0] b);
        frame_check = frame_check ^ b;
        hold_word(b, 1'b0);
    endfunction

    function automatic int digit_count(logic [7:0] v);
        return (v >= 100) ? 3 : ((v >= 10) ? 2 : 1);
    endfunction

    // Control string such as [m12] with the value in decimal.
    function automatic void hold_control(logic [7:0] letter, logic [7:0] v);
        hold_checked(ASCII_LBRK);
        hold_checked(letter);
        if (v >= 100) hold_checked(ASCII_ZERO + v / 100);
        if (v >= 10) hold_checked(ASCII_ZERO + (v / 10) % 10);
        hold_checked(ASCII_ZERO + v % 10);
        hold_checked(ASCII_RBRK);
    endfunction

    function automatic void drop_open_frame();
        frame_check = '0;
        text_left   = '0;
        frame_open  = 1'b0;
    endfunction

    function automatic void close_frame();
        hold_word(frame_check, 1'b1);
        drop_open_frame();
    endfunction

    function automatic void hold_fixed(logic [7:0] cmd, logic [7:0] chk);
        hold_word(BYTE_HEAD, 1'b0);
        hold_word(BYTE_ZERO, 1'b0);
        hold_word(FIXED_LEN, 1'b0);
        hold_word(cmd, 1'b0);
        hold_word(chk, 1'b1);
    endfunction

    // Work out the frame bytes an accepted item releases and queue them as expected words.
    function automatic void predict_frame_words(t_speech_item it);
        int          tlen;
        logic [15:0] dlen;
        int          n;
        t_frame_word w;
        case (it.func)
            FUNC_START: begin
                drop_open_frame();
                tlen = (it.text_length > MAX_TEXT) ? MAX_TEXT : it.text_length;
                dlen = 16'((3 + digit_count(it.music_volume)) +
                           (3 + digit_count(it.voice_volume)) + tlen + 3);
                hold_checked(BYTE_HEAD);
                hold_checked(dlen[15:8]);
                hold_checked(dlen[7:0]);
                hold_checked(CMD_SPEAK);
                hold_checked({1'b0, it.music_number, it.text_encoding});
                hold_control(ASCII_M, it.music_volume);
                hold_control(ASCII_V, it.voice_volume);
                if (tlen == 0) begin
                    close_frame();
                end else begin
                    text_left  = 8'(tlen);
                    frame_open = 1'b1;
                end
            end
            FUNC_TEXT: begin
                if (frame_open) begin
                    hold_checked(it.text_byte);
                    text_left = text_left - 8'd1;
                    if (text_left == 0) close_frame();
                end
            end
            FUNC_STOP: begin
                drop_open_frame();
                hold_fixed(CMD_STOP, CHK_STOP);
            end
            FUNC_SLEEP: begin
                drop_open_frame();
                hold_fixed(CMD_SLEEP, CHK_SLEEP);
            end
            FUNC_WAKE: begin
                drop_open_frame();
                hold_fixed(CMD_WAKE, CHK_WAKE);
                hold_fixed(CMD_WAKE, CHK_WAKE);
            end
            default: begin
            end
        endcase

        // Each item releases at most one run from the head of the hold queue.
        n = (held_words.size() < RUN_MAX) ? held_words.size() : RUN_MAX;
        for (int k = 0; k < n; k++) begin
            w = held_words.pop_front();
            w.last_of_run = (k == n - 1);
            expected_words.push_back(w);
        end
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    function automatic t_speech_item make_item(logic [2:0] func, logic [7:0] mvol,
                                               logic [3:0] mnum, logic [7:0] vvol,
                                               logic [2:0] enc, logic [7:0] tlen,
                                               logic [7:0] tb);
        t_speech_item it;
        it.func          = func;
        it.music_volume  = mvol;
        it.music_number  = mnum;
        it.voice_volume  = vvol;
        it.text_encoding = enc;
        it.text_length   = tlen;
        it.text_byte     = tb;
        return it;
    endfunction

    // Volumes spread evenly over one, two and three decimal digits.
    function automatic logic [7:0] rand_volume();
        case ($urandom_range(2))
            0: return 8'($urandom_range(9));
            1: return 8'($urandom_range(99, 10));
            default: return 8'($urandom_range(255, 100));
        endcase
    endfunction

    function automatic t_speech_item rand_item(logic [2:0] func);
        return make_item(func, rand_volume(), 4'($urandom), rand_volume(), 3'($urandom),
                         8'($urandom), 8'($urandom));
    endfunction

    // ---------------------------------------------------------------- item driver

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            item_ch.valid         <= 1'b0;
            item_ch.func          <= '0;
            item_ch.music_volume  <= '0;
            item_ch.music_number  <= '0;
            item_ch.voice_volume  <= '0;
            item_ch.text_encoding <= '0;
            item_ch.text_length   <= '0;
            item_ch.text_byte     <= '0;
            items_accepted        <= 0;
        end else begin
            if (item_ch.valid && item_ch.ready) begin
                predict_frame_words(item_offered);
                items_accepted <= items_accepted + 1;
            end
            // Offer the next item only once the current one has gone.
            if (!item_ch.valid || item_ch.ready) begin
                if (item_pending.size() != 0 && $urandom_range(99) >= idle_pct(1'b0)) begin
                    item_offered = item_pending.pop_front();
                    item_ch.valid         <= 1'b1;
                    item_ch.func          <= item_offered.func;
                    item_ch.music_volume  <= item_offered.music_volume;
                    item_ch.music_number  <= item_offered.music_number;
                    item_ch.voice_volume  <= item_offered.voice_volume;
                    item_ch.text_encoding <= item_offered.text_encoding;
                    item_ch.text_length   <= item_offered.text_length;
                    item_ch.text_byte     <= item_offered.text_byte;
                end else begin
                    item_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------- receiver hold-off

    // One long stall of the receiver in the no-idle phase, so the block backs up.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_hold_left <= 0;
            rx_hold_done <= 1'b0;
        end else if (rx_hold_left != 0) begin
            rx_hold_left <= rx_hold_left - 1;
        end else if (!rx_hold_done && items_accepted >= 2 * item_total / 3 + 20) begin
            rx_hold_left <= HOLD_OFF_CYCLES;
            rx_hold_done <= 1'b1;
        end
    end

    // ---------------------------------------------------------------- result monitor

    always @(posedge i_clk) begin : result_monitor
        t_frame_word want;
        if (!i_rst_n) begin
            result_ch.ready <= 1'b0;
        end else begin
            if (result_ch.valid && result_ch.ready) begin
                if (expected_words.size() == 0) begin
                    $error("unexpected word: frame_byte %02h", result_ch.frame_byte);
                    mismatch_count++;
                end else begin
                    want = expected_words.pop_front();
                    if (result_ch.frame_byte !== want.frame_byte) begin
                        $error("frame_byte: expected %02h, got %02h",
                               want.frame_byte, result_ch.frame_byte);
                        mismatch_count++;
                    end
                    if (result_ch.last_of_run !== want.last_of_run) begin
                        $error("last_of_run: expected %0b, got %0b",
                               want.last_of_run, result_ch.last_of_run);
                        mismatch_count++;
                    end
                    if (result_ch.frame_end !== want.frame_end) begin
                        $error("frame_end: expected %0b, got %0b",
                               want.frame_end, result_ch.frame_end);
                        mismatch_count++;
                    end
                end
            end
            result_ch.ready <= (rx_hold_left == 0) && ($urandom_range(99) >= idle_pct(1'b1));
        end
    end

    // ---------------------------------------------------------------- run control

    initial begin : run_control
        t_speech_item it;
        int           tl;
        int           n;
        int           r;

        i_rst_n               = 1'b0;
        item_ch.valid         = 1'b0;
        item_ch.func          = '0;
        item_ch.music_volume  = '0;
        item_ch.music_number  = '0;
        item_ch.voice_volume  = '0;
        item_ch.text_encoding = '0;
        item_ch.text_length   = '0;
        item_ch.text_byte     = '0;
        result_ch.ready       = 1'b0;
        mismatch_count        = 0;
        frame_check           = '0;
        text_left             = '0;
        frame_open            = 1'b0;

        // Empty text: the check byte follows the header at once.
        item_pending.push_back(make_item(FUNC_START, 8'd0, 4'd0, 8'd0, 3'd0, 8'd0, 8'd0));
        // Largest fields and a short text that closes normally.
        item_pending.push_back(make_item(FUNC_START, 8'd255, 4'd15, 8'd255, 3'd7, 8'd3, 8'd0));
        item_pending.push_back(make_item(FUNC_TEXT, 8'd0, 4'd0, 8'd0, 3'd0, 8'd0, 8'h00));
        item_pending.push_back(make_item(FUNC_TEXT, 8'd0, 4'd0, 8'd0, 3'd0, 8'd0, 8'hFF));
        item_pending.push_back(make_item(FUNC_TEXT, 8'd0, 4'd0, 8'd0, 3'd0, 8'd0, 8'hA5));
        // Text with no frame open.
        item_pending.push_back(make_item(FUNC_TEXT, 8'd0, 4'd0, 8'd0, 3'd0, 8'd0, 8'h5A));
        // Saturated length, then a new start abandons the open frame.
        item_pending.push_back(make_item(FUNC_START, 8'd9, 4'd1, 8'd10, 3'd3, 8'd255, 8'd0));
        item_pending.push_back(make_item(FUNC_TEXT, 8'd0, 4'd0, 8'd0, 3'd0, 8'd0, 8'h11));
        item_pending.push_back(make_item(FUNC_TEXT, 8'd0, 4'd0, 8'd0, 3'd0, 8'd0, 8'h22));
        item_pending.push_back(make_item(FUNC_START, 8'd99, 4'd8, 8'd100, 3'd4, 8'd2, 8'd0));
        item_pending.push_back(make_item(FUNC_TEXT, 8'd0, 4'd0, 8'd0, 3'd0, 8'd0, 8'h33));
        // Fixed frames; the stop abandons the open frame.
        item_pending.push_back(make_item(FUNC_STOP, 8'd0, 4'd0, 8'd0, 3'd0, 8'd0, 8'd0));
        item_pending.push_back(make_item(FUNC_SLEEP, 8'd0, 4'd0, 8'd0, 3'd0, 8'd0, 8'd0));
        item_pending.push_back(make_item(FUNC_WAKE, 8'd0, 4'd0, 8'd0, 3'd0, 8'd0, 8'd0));
        // Unused function codes.
        for (int c = 5; c < 8; c++)
            item_pending.push_back(make_item(3'(c), 8'd0, 4'd0, 8'd0, 3'd0, 8'd0, 8'd0));
        // Back-to-back long headers grow the hold queue until it overflows.
        for (int k = 0; k < 12; k++)
            item_pending.push_back(make_item(FUNC_START, 8'd255, 4'($urandom), 8'd255,
                                             3'($urandom), 8'd0, 8'd0));
        // A silent text item releases one more run of what is still held.
        item_pending.push_back(make_item(FUNC_TEXT, 8'd0, 4'd0, 8'd0, 3'd0, 8'd0, 8'h77));

        // Random part: mostly whole frames with random text, some noise and cut-off frames.
        n = item_pending.size() + RANDOM_ITEMS;
        while (item_pending.size() < n) begin
            if ($urandom_range(99) < 20) begin
                item_pending.push_back(rand_item(3'($urandom_range(7))));
            end else begin
                it = rand_item(FUNC_START);
                r = $urandom_range(99);
                tl = (r < 80) ? $urandom_range(12) :
                     (r < 95) ? $urandom_range(40, 13) : $urandom_range(255);
                it.text_length = 8'(tl);
                item_pending.push_back(it);
                if (tl > MAX_TEXT) tl = MAX_TEXT;
                if ($urandom_range(99) < 10) tl = $urandom_range(tl);
                repeat (tl) item_pending.push_back(rand_item(FUNC_TEXT));
            end
        end
        item_total = item_pending.size();

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for all items to be taken, all results to arrive, then a quiet tail.
        while (item_pending.size() != 0 || item_ch.valid) @(posedge i_clk);
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("speech_command_frame_builder regression: pass");
        end else begin
            $display("speech_command_frame_builder regression: fail");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #4000000;
        $display("speech_command_frame_builder regression: fail");
        $finish;
    end

endmodule
